>>> hdl/ssgm_pkg.sv
package ssgm_pkg;

    localparam int DefaultCapacity = 128;

    // Request kinds carried on s_tuser
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_MATCH  = 2'd1;
    localparam logic [1:0] REQ_FIND   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // Result status carried on m_tuser
    localparam logic [2:0] STAT_INSERTED = 3'd0;
    localparam logic [2:0] STAT_FULL     = 3'd1;
    localparam logic [2:0] STAT_MATCH    = 3'd2;
    localparam logic [2:0] STAT_NO_MATCH = 3'd3;
    localparam logic [2:0] STAT_CLEARED  = 3'd4;

    typedef struct packed {
        logic [31:0] group_id;
        logic [31:0] prefix;
        logic [5:0]  shift;
        logic [15:0] port_number;
    } entry_t;

    // Shift by 32 or more yields zero, so a zero-length prefix matches all.
    function automatic logic [31:0] prefix_of(input logic [31:0] addr,
                                              input logic [5:0] sh);
        logic [31:0] res;
        if (sh >= 6'd32) begin
            res = '0;
        end else begin
            res = addr >> sh;
        end
        return res;
    endfunction

    function automatic logic entry_hit(input entry_t e, input logic [31:0] addr,
                                       input logic [15:0] port);
        logic pfx_eq;
        logic port_eq;
        pfx_eq  = (e.prefix == prefix_of(addr, e.shift));
        port_eq = (e.port_number == port) || (e.port_number == 16'd0);
        return pfx_eq && port_eq;
    endfunction

endpackage

>>> hdl/ssgm_entry_ram.sv
module ssgm_entry_ram #(
    parameter int DEPTH = ssgm_pkg::DefaultCapacity,
    parameter int IW    = 7
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [IW-1:0]        waddr,
    input  ssgm_pkg::entry_t     wdata,
    input  logic                 re,
    input  logic [IW-1:0]        raddr,
    output ssgm_pkg::entry_t     rdata
);

    ssgm_pkg::entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/sorted_subnet_group_matcher.sv
// Sorted IPv4 subnet access table. Each accepted item is one request (s_tuser):
// insert a subnet entry, match an address/port within one group, find the group
// of the first entry that matches an address/port, or clear the table; every
// request returns exactly one result item with a status on m_tuser and, for a
// successful find, the group on m_tdata (zero otherwise). Entries live in one
// single-port-read, single-port-write RAM with a registered read port and
// are kept sorted by group, ties in insertion order. A clear, a full-table
// insert or a lookup in an empty table needs no RAM access; an insert moves
// each entry with a larger group up one slot per cycle through the RAM; a
// match or find does one RAM read per entry scanned, so at most
// SUBNET_CAPACITY reads. The block takes one item at a time and accepts the
// next once the current result sits in the output register.
// No clearing pass is needed after reset: only entries below the fill count
// are ever read.
module sorted_subnet_group_matcher #(
    parameter int SUBNET_CAPACITY = ssgm_pkg::DefaultCapacity
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // group_id[31:0], ip_address[63:32],
                                  // prefix_length[69:64], port_number[85:70], zero pad
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // found_group[31:0]
    output logic [2:0]  m_tuser   // status[2:0]
);

    localparam int IW = (SUBNET_CAPACITY > 1) ? $clog2(SUBNET_CAPACITY) : 1;
    localparam int CW = $clog2(SUBNET_CAPACITY + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INS   = 3'd1;
    localparam logic [2:0] ST_PLACE = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [1:0]        req_reg, req_next;
    logic [31:0]       addr_reg, addr_next;
    logic [15:0]       port_reg, port_next;
    ssgm_pkg::entry_t  new_reg, new_next;
    logic [2:0]        res_stat_reg, res_stat_next;
    logic [31:0]       res_grp_reg, res_grp_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [2:0]        m_tuser_reg, m_tuser_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    // Input field unpacking
    logic [31:0] in_group;
    logic [31:0] in_addr;
    logic [5:0]  in_plen;
    logic [15:0] in_port;
    logic [5:0]  in_shift;

    assign in_group = s_tdata[31:0];
    assign in_addr  = s_tdata[63:32];
    assign in_plen  = s_tdata[69:64];
    assign in_port  = s_tdata[85:70];
    // Saturate prefix length to 32, then the shift is 32 minus it.
    assign in_shift = 6'd32 - ((in_plen > 6'd32) ? 6'd32 : in_plen);

    // RAM port signals
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    ssgm_pkg::entry_t  ram_wdata;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    ssgm_pkg::entry_t  ram_rdata;

    ssgm_entry_ram #(
        .DEPTH (SUBNET_CAPACITY),
        .IW    (IW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic          s_accept;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] scan_nxt;
    logic          rd_hit;
    logic          out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cnt_m1   = count_reg - CW'(1);
    assign scan_nxt = CW'(idx_reg) + CW'(1);
    assign rd_hit   = ssgm_pkg::entry_hit(ram_rdata, addr_reg, port_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        req_next      = req_reg;
        addr_next     = addr_reg;
        port_next     = port_reg;
        new_next      = new_reg;
        res_stat_next = res_stat_reg;
        res_grp_next  = res_grp_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = new_reg;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg;

        // Drop the result once the sink takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_next              = s_tuser;
                    addr_next             = in_addr;
                    port_next             = in_port;
                    new_next.group_id     = in_group;
                    new_next.prefix       = ssgm_pkg::prefix_of(in_addr, in_shift);
                    new_next.shift        = in_shift;
                    new_next.port_number  = in_port;
                    res_grp_next          = '0;
                    state_next            = ST_DONE;
                    case (s_tuser)
                        ssgm_pkg::REQ_CLEAR: begin
                            count_next    = '0;
                            res_stat_next = ssgm_pkg::STAT_CLEARED;
                        end
                        ssgm_pkg::REQ_INSERT: begin
                            if (count_reg == CW'(SUBNET_CAPACITY)) begin
                                res_stat_next = ssgm_pkg::STAT_FULL;
                            end else if (count_reg == '0) begin
                                // Empty table: place the first entry directly.
                                idx_next   = '0;
                                state_next = ST_PLACE;
                            end else begin
                                // Read the last entry and start moving up.
                                ram_re     = 1'b1;
                                ram_raddr  = cnt_m1[IW-1:0];
                                idx_next   = count_reg[IW-1:0];
                                state_next = ST_INS;
                            end
                        end
                        default: begin
                            res_stat_next = ssgm_pkg::STAT_NO_MATCH;
                            if (count_reg != '0) begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            ST_INS: begin
                // ram_rdata holds the entry just below the free slot idx_reg.
                if (ram_rdata.group_id > new_reg.group_id) begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    ram_wdata = ram_rdata;
                    idx_next  = idx_reg - IW'(1);
                    if (idx_reg == IW'(1)) begin
                        state_next = ST_PLACE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg - IW'(2);
                    end
                end else begin
                    ram_we        = 1'b1;
                    ram_waddr     = idx_reg;
                    ram_wdata     = new_reg;
                    count_next    = count_reg + CW'(1);
                    res_stat_next = ssgm_pkg::STAT_INSERTED;
                    state_next    = ST_DONE;
                end
            end

            ST_PLACE: begin
                ram_we        = 1'b1;
                ram_waddr     = idx_reg;
                ram_wdata     = new_reg;
                count_next    = count_reg + CW'(1);
                res_stat_next = ssgm_pkg::STAT_INSERTED;
                state_next    = ST_DONE;
            end

            ST_SCAN: begin
                if (req_reg == ssgm_pkg::REQ_FIND) begin
                    if (rd_hit) begin
                        res_stat_next = ssgm_pkg::STAT_MATCH;
                        res_grp_next  = ram_rdata.group_id;
                        state_next    = ST_DONE;
                    end
                end else begin
                    // Entries are sorted: stop once past the requested group.
                    if (ram_rdata.group_id > new_reg.group_id) begin
                        state_next = ST_DONE;
                    end else if (ram_rdata.group_id == new_reg.group_id && rd_hit) begin
                        res_stat_next = ssgm_pkg::STAT_MATCH;
                        state_next    = ST_DONE;
                    end
                end
                if (state_next == ST_SCAN) begin
                    if (scan_nxt == count_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = scan_nxt[IW-1:0];
                        idx_next  = scan_nxt[IW-1:0];
                    end
                end
            end

            ST_DONE: begin
                // Hold the result until the output register is free.
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_stat_reg;
                    m_tdata_next  = res_grp_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        req_reg      <= req_next;
        addr_reg     <= addr_next;
        port_reg     <= port_next;
        new_reg      <= new_next;
        res_stat_reg <= res_stat_next;
        res_grp_reg  <= res_grp_next;
        m_tuser_reg  <= m_tuser_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hdl/ssgm_checker.sv
module ssgm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Status stays within the defined codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ssgm_pkg::STAT_CLEARED))
        else $error("undefined status code");

    // A nonzero group is only reported with a match.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata != 32'd0) |-> (m_tuser == ssgm_pkg::STAT_MATCH))
        else $error("group reported without match");

    // One item at a time: busy right after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted two items back to back");

    // A clear is handled like any request: the block is busy the cycle after.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ssgm_pkg::REQ_CLEAR) |=> !s_tready)
        else $error("clear did not occupy the block");

endmodule

bind sorted_subnet_group_matcher ssgm_checker u_ssgm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/sorted_subnet_group_matcher_tb.sv
`timescale 1ns / 1ps

module sorted_subnet_group_matcher_tb;

    localparam int CAPACITY    = 128;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 20;

    // One request as it travels on the input channel
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] group_id;
        logic [31:0] ip_address;
        logic [5:0]  prefix_length;
        logic [15:0] port_number;
    } request_t;

    // One response as it travels on the output channel
    typedef struct {
        logic [2:0]  status;
        logic [31:0] found_group;
    } response_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;  // group_id[31:0], ip_address[63:32],
                                // prefix_length[69:64], port_number[85:70], zero pad
    logic [1:0]  s_tuser = '0;  // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;       // found_group[31:0]
    logic [2:0]  m_tuser;       // status[2:0]

    sorted_subnet_group_matcher #(
        .SUBNET_CAPACITY(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the subnet table, kept sorted by group like the block's
    int          tbl_count;
    logic [31:0] tbl_group  [CAPACITY];
    logic [31:0] tbl_prefix [CAPACITY];
    logic [5:0]  tbl_shift  [CAPACITY];
    logic [15:0] tbl_port   [CAPACITY];

    request_t  pending_requests[$];   // filled by the stimulus, drained by the driver
    response_t expected_responses[$]; // predicted at acceptance, consumed by the monitor
    request_t  session_entries[$];    // inserts since the last clear, for aimed lookups
    logic [31:0] group_pool[4];

    int errors;
    int cycle_count;
    int sent_count;
    int recv_count;
    int send_gap;
    int stall_left;
    request_t  cur_request;
    response_t want;

    // Entry k covers the address when the address's top bits equal the stored
    // prefix; a shift of 32 leaves nothing, so a zero-length prefix covers all.
    function automatic bit entry_covers(input int k, input logic [31:0] addr,
                                        input logic [15:0] port);
        logic [31:0] top_bits;
        top_bits = addr >> tbl_shift[k];
        return (tbl_prefix[k] == top_bits) &&
               (tbl_port[k] == port || tbl_port[k] == 16'd0);
    endfunction

    // Advance the shadow table by one request and return the response it owes
    function automatic response_t apply_request(input request_t rq);
        response_t   rs;
        int          k;
        logic [5:0]  plen;
        logic [5:0]  sh;
        rs.status      = ssgm_pkg::STAT_NO_MATCH;
        rs.found_group = '0;
        case (rq.kind)
            ssgm_pkg::REQ_INSERT: begin
                if (tbl_count >= CAPACITY) begin
                    rs.status = ssgm_pkg::STAT_FULL;
                end else begin
                    // Saturate lengths above 32 to an exact-address entry
                    plen = (rq.prefix_length > 6'd32) ? 6'd32 : rq.prefix_length;
                    sh   = 6'd32 - plen;
                    // Move larger groups up one slot; equal groups stay ahead
                    k = tbl_count;
                    while (k > 0 && tbl_group[k-1] > rq.group_id) begin
                        tbl_group[k]  = tbl_group[k-1];
                        tbl_prefix[k] = tbl_prefix[k-1];
                        tbl_shift[k]  = tbl_shift[k-1];
                        tbl_port[k]   = tbl_port[k-1];
                        k--;
                    end
                    tbl_group[k]  = rq.group_id;
                    tbl_prefix[k] = rq.ip_address >> sh;
                    tbl_shift[k]  = sh;
                    tbl_port[k]   = rq.port_number;
                    tbl_count++;
                    rs.status = ssgm_pkg::STAT_INSERTED;
                end
            end
            ssgm_pkg::REQ_MATCH: begin
                k = 0;
                while (k < tbl_count && tbl_group[k] < rq.group_id) k++;
                while (k < tbl_count && tbl_group[k] == rq.group_id) begin
                    if (entry_covers(k, rq.ip_address, rq.port_number)) begin
                        rs.status = ssgm_pkg::STAT_MATCH;
                        break;
                    end
                    k++;
                end
            end
            ssgm_pkg::REQ_FIND: begin
                for (k = 0; k < tbl_count; k++) begin
                    if (entry_covers(k, rq.ip_address, rq.port_number)) begin
                        rs.status      = ssgm_pkg::STAT_MATCH;
                        rs.found_group = tbl_group[k];
                        break;
                    end
                end
            end
            default: begin
                // Clear only drops the fill count
                tbl_count = 0;
                rs.status = ssgm_pkg::STAT_CLEARED;
            end
        endcase
        return rs;
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Mostly short gaps, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_request(input logic [1:0] kind, input logic [31:0] grp,
                                 input logic [31:0] addr, input logic [5:0] plen,
                                 input logic [15:0] port);
        request_t rq;
        rq.kind          = kind;
        rq.group_id      = grp;
        rq.ip_address    = addr;
        rq.prefix_length = plen;
        rq.port_number   = port;
        pending_requests.push_back(rq);
        if (kind == ssgm_pkg::REQ_INSERT) session_entries.push_back(rq);
        if (kind == ssgm_pkg::REQ_CLEAR) session_entries.delete();
    endtask

    // Queue one match or find; most aim at a stored subnet with random host
    // bits, some are blind, and a few are pure noise of any kind.
    task automatic gen_lookup();
        request_t    e;
        logic [1:0]  kind;
        logic [31:0] mask;
        logic [31:0] addr;
        logic [31:0] grp;
        logic [15:0] port;
        int          eff;
        int          r;
        kind = ($urandom_range(0, 1) != 0) ? ssgm_pkg::REQ_MATCH : ssgm_pkg::REQ_FIND;
        r    = $urandom_range(0, 99);
        if (r < 4) begin
            queue_request(2'($urandom), $urandom, $urandom, 6'($urandom), 16'($urandom));
        end else if (r < 74 && session_entries.size() > 0) begin
            e    = session_entries[$urandom_range(0, session_entries.size() - 1)];
            eff  = (e.prefix_length > 6'd32) ? 32 : int'(e.prefix_length);
            mask = ~(32'hFFFF_FFFF >> eff);
            addr = (e.ip_address & mask) | ($urandom & ~mask);
            if (e.port_number != 16'd0 && $urandom_range(0, 99) < 80)
                port = e.port_number;
            else
                port = 16'($urandom);
            grp = ($urandom_range(0, 99) < 85) ? e.group_id
                                               : group_pool[$urandom_range(0, 3)];
            queue_request(kind, grp, addr, 6'($urandom), port);
        end else begin
            queue_request(kind, group_pool[$urandom_range(0, 3)], $urandom,
                          6'($urandom), 16'($urandom));
        end
    endtask

    // Driver: present the next pending item, hold it until accepted, then
    // idle for a random gap. Predict the response at the accepting edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_responses.push_back(apply_request(cur_request));
                sent_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    cur_request = pending_requests.pop_front();
                    s_tdata  <= {2'b00, cur_request.port_number, cur_request.prefix_length,
                                 cur_request.ip_address, cur_request.group_id};
                    s_tuser  <= cur_request.kind;
                    s_tvalid <= 1'b1;
                    // Every fourth stretch of 40 items goes back to back
                    send_gap = ((sent_count / 40) % 4 == 3) ? 0 : idle_length();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted response with the oldest prediction,
    // and stall the output side at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                recv_count++;
                if (expected_responses.size() == 0) begin
                    note_failure($sformatf("unexpected response status=%0d group=%h",
                                           m_tuser, m_tdata));
                end else begin
                    want = expected_responses.pop_front();
                    if (m_tuser !== want.status)
                        note_failure($sformatf("response %0d status: expected %0d, got %0d",
                                               recv_count, want.status, m_tuser));
                    if (m_tdata !== want.found_group)
                        note_failure($sformatf("response %0d group: expected %h, got %h",
                                               recv_count, want.found_group, m_tdata));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                // Keep the output side open through one stretch in four
                if ((recv_count / 40) % 4 != 1 && $urandom_range(0, 99) < 30)
                    stall_left = idle_length();
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int          session;
        int          n_ins;
        int          n_look;
        int          i;
        int          r;
        logic [5:0]  plen;
        logic [15:0] port;
        logic [31:0] grp;

        // Directed: empty-table lookups, sorted inserts with extreme fields,
        // zero-length and over-long prefixes, hits, misses, clear.
        queue_request(ssgm_pkg::REQ_MATCH,  32'd0,         32'h0000_0000, 6'd0,  16'd0);
        queue_request(ssgm_pkg::REQ_FIND,   32'd0,         32'hFFFF_FFFF, 6'd0,  16'hFFFF);
        queue_request(ssgm_pkg::REQ_INSERT, 32'd5,         32'hC0A8_0100, 6'd24, 16'd80);
        queue_request(ssgm_pkg::REQ_INSERT, 32'd2,         32'h0A00_0000, 6'd8,  16'd0);
        queue_request(ssgm_pkg::REQ_INSERT, 32'd5,         32'h0000_0000, 6'd0,  16'd0);
        queue_request(ssgm_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32, 16'hFFFF);
        queue_request(ssgm_pkg::REQ_INSERT, 32'd0,         32'h1234_5678, 6'd63, 16'd1);
        queue_request(ssgm_pkg::REQ_INSERT, 32'd2,         32'h8000_0000, 6'd1,  16'd443);
        queue_request(ssgm_pkg::REQ_MATCH,  32'd5,         32'hC0A8_01FF, 6'd0,  16'd80);
        queue_request(ssgm_pkg::REQ_MATCH,  32'd5,         32'h0102_0304, 6'd0,  16'd9);
        queue_request(ssgm_pkg::REQ_MATCH,  32'd3,         32'hC0A8_0101, 6'd0,  16'd80);
        queue_request(ssgm_pkg::REQ_FIND,   32'd0,         32'h0A01_0203, 6'd0,  16'd7);
        queue_request(ssgm_pkg::REQ_FIND,   32'd0,         32'hFFFF_FFFF, 6'd0,  16'hFFFF);
        queue_request(ssgm_pkg::REQ_MATCH,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0,  16'hFFFE);
        queue_request(ssgm_pkg::REQ_MATCH,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0,  16'hFFFF);
        queue_request(ssgm_pkg::REQ_MATCH,  32'd0,         32'h1234_5678, 6'd0,  16'd1);
        queue_request(ssgm_pkg::REQ_MATCH,  32'd0,         32'h1234_5679, 6'd0,  16'd1);
        queue_request(ssgm_pkg::REQ_MATCH,  32'd2,         32'hFFFF_0000, 6'd0,  16'd443);
        queue_request(ssgm_pkg::REQ_CLEAR,  32'd0,         32'h0,         6'd0,  16'd0);
        queue_request(ssgm_pkg::REQ_FIND,   32'd0,         32'h0A01_0203, 6'd0,  16'd7);
        queue_request(ssgm_pkg::REQ_MATCH,  32'd2,         32'h0A01_0203, 6'd0,  16'd7);

        // Random sessions: mostly clear, a run of inserts into a few groups,
        // then lookups aimed at them. Session 2 overfills the table.
        session = 0;
        while (pending_requests.size() < 500) begin
            for (i = 0; i < 4; i++) begin
                r = $urandom_range(0, 9);
                group_pool[i] = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF :
                                (r < 6) ? 32'($urandom_range(0, 20)) : $urandom;
            end
            if (session == 2 || $urandom_range(0, 99) < 80)
                queue_request(ssgm_pkg::REQ_CLEAR, $urandom, $urandom,
                              6'($urandom), 16'($urandom));
            n_ins = (session == 2) ? $urandom_range(CAPACITY + 1, CAPACITY + 4)
                                   : $urandom_range(1, 16);
            for (i = 0; i < n_ins; i++) begin
                r    = $urandom_range(0, 99);
                plen = (r < 6) ? 6'd0 : (r < 12) ? 6'($urandom_range(33, 63)) :
                       (r < 30) ? 6'($urandom_range(1, 7)) : 6'($urandom_range(8, 32));
                r    = $urandom_range(0, 99);
                port = (r < 25) ? 16'd0 : (r < 60) ? 16'($urandom_range(1, 4)) : 16'($urandom);
                grp  = ($urandom_range(0, 99) < 90) ? group_pool[$urandom_range(0, 3)]
                                                    : $urandom;
                queue_request(ssgm_pkg::REQ_INSERT, grp, $urandom, plen, port);
                if ($urandom_range(0, 99) < 25) gen_lookup();
            end
            n_look = $urandom_range(4, 16);
            for (i = 0; i < n_look; i++) gen_lookup();
            session++;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every item to be taken and every response to come back
        while (pending_requests.size() > 0 || s_tvalid) @(posedge aclk);
        while (expected_responses.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (expected_responses.size() > 0)
            note_failure($sformatf("%0d responses never arrived", expected_responses.size()));

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sorted_subnet_group_matcher.f
hdl/ssgm_pkg.sv
hdl/ssgm_entry_ram.sv
hdl/sorted_subnet_group_matcher.sv
hdl/ssgm_checker.sv
dv/sorted_subnet_group_matcher_tb.sv
